// ----- rtl/lrups_pkg.sv -----
// Shared types and constants for the LRU page replacement stack.
package lrups_pkg;

   localparam int PAGE_W  = 32;  // request page number field
   localparam int COUNT_W = 32;  // request and miss totals
   localparam int CFG_W   = 5;   // table_size register

   localparam logic [CFG_W-1:0]   TABLE_SIZE_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};

   // Per-cell control, driven by the top level.
   typedef struct packed {
      logic step;   // a non-zero request is being taken this cycle
      logic live;   // cell index is below the fill level
      logic slide;  // cell index is inside the shift window
   } lrups_cell_ctl_type;

endpackage

// ----- rtl/lrups_if.sv -----
// Channel interfaces: request, response and table_size write port.
interface lrups_req_if import lrups_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lrups_rsp_if import lrups_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               ignored;
   logic               hit;
   logic               fault;
   logic [COUNT_W-1:0] request_total;
   logic [COUNT_W-1:0] miss_total;

   modport source (output valid, output ignored, output hit, output fault,
                   output request_total, output miss_total, input ready);
   modport sink   (input valid, input ignored, input hit, input fault,
                   input request_total, input miss_total, output ready);
endinterface

interface lrups_csr_if import lrups_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] table_size;

   modport source (output valid, output table_size, input ready);
   modport sink   (input valid, input table_size, output ready);
endinterface

// ----- rtl/lrups_cell.sv -----
// One stack cell: holds a page, compares it, and takes its neighbor's page on a shift.
module lrups_cell import lrups_pkg::*; #(
   parameter int KEY_BITS = 32
) (
   input  logic                clock,
   input  lrups_cell_ctl_type  ctl,
   input  logic [KEY_BITS-1:0] page,
   input  logic [KEY_BITS-1:0] prev_entry,
   input  logic                seen_in,
   output logic [KEY_BITS-1:0] entry,
   output logic                seen_out
);

   logic [KEY_BITS-1:0] entry_ff;
   logic                match;

   assign match    = ctl.live && (entry_ff == page);
   assign seen_out = seen_in | match;
   assign entry    = entry_ff;

   // A cell past the hit slot keeps its page; the hit slot and the cells in front move back.
   always_ff @(posedge clock) begin
      if (ctl.step && ctl.slide && !seen_in) begin
         entry_ff <= prev_entry;
      end
   end

endmodule

// ----- rtl/lru_page_replacement_stack.sv -----
// Top level: LRU recency stack built as a row of compare-and-shift cells.
//
//   port     dir  beat carries
//   req_bus  in   page_number
//   rsp_bus  out  ignored, hit, fault, request_total, miss_total
//   csr_bus  in   table_size
//
// One request per cycle while the output register can take it: every cell compares and the
// shift window shifts in the same cycle, the hit position ripples down the cell row as a seen flag.
// Response sits in an output register; a new request is taken while the
// register is empty or being drained.
// Synchronous reset clears fill level, totals and response valid and sets table_size to 16; no
// clearing pass, stack entries beyond the fill level are never compared.
module lru_page_replacement_stack import lrups_pkg::*; #(
   parameter int DEPTH     = 16,
   parameter int PAGE_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   lrups_req_if.sink      req_bus,
   lrups_rsp_if.source    rsp_bus,
   lrups_csr_if.sink      csr_bus
);

   localparam int KEY_BITS = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int FILL_W   = $clog2(DEPTH + 1);
   localparam int CMP_W    = (FILL_W > CFG_W) ? FILL_W : CFG_W;

   logic [CFG_W-1:0]   table_size_ff;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] req_cnt_ff, req_cnt_in;
   logic [COUNT_W-1:0] miss_cnt_ff, miss_cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               ignored_ff, hit_ff, fault_ff;

   logic [KEY_BITS-1:0] page;
   logic                ignored, hit, go;
   logic [CMP_W-1:0]    ts_wide;
   logic [FILL_W-1:0]   size, fill_cut, lim;

   logic [KEY_BITS-1:0] entry [DEPTH];
   logic                seen  [DEPTH+1];

   assign page    = req_bus.page_number[KEY_BITS-1:0];
   assign ignored = (page == '0);

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign go            = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Frames in use: zero acts as one, anything above DEPTH acts as DEPTH.
   always_comb begin
      ts_wide = CMP_W'(table_size_ff);
      if (ts_wide == '0) begin
         size = FILL_W'(1);
      end else if (ts_wide > CMP_W'(DEPTH)) begin
         size = FILL_W'(DEPTH);
      end else begin
         size = ts_wide[FILL_W-1:0];
      end
      fill_cut = (fill_ff > size) ? size : fill_ff;
      // Deepest cell that may shift: on a miss the filled part and the next free
      // cell (last frame when full); on a hit the seen flag cuts it further.
      lim = (fill_cut < size - FILL_W'(1)) ? fill_cut : size - FILL_W'(1);
   end

   assign seen[0] = 1'b0;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      lrups_cell_ctl_type  ctl;
      logic [KEY_BITS-1:0] prev_entry;

      assign ctl.step  = go && !ignored;
      assign ctl.live  = FILL_W'(k) < fill_cut;
      assign ctl.slide = FILL_W'(k) <= lim;

      if (k == 0) begin : g_head
         assign prev_entry = page;
      end else begin : g_body
         assign prev_entry = entry[k-1];
      end

      lrups_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .page       (page),
         .prev_entry (prev_entry),
         .seen_in    (seen[k]),
         .entry      (entry[k]),
         .seen_out   (seen[k+1])
      );
   end

   assign hit = seen[DEPTH];

   always_comb begin
      fill_in      = fill_ff;
      req_cnt_in   = req_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (go) begin
         rsp_valid_in = 1'b1;
         if (!ignored) begin
            fill_in = fill_cut;
            if (req_cnt_ff != COUNT_MAX) begin
               req_cnt_in = req_cnt_ff + COUNT_W'(1);
            end
            if (!hit) begin
               if (miss_cnt_ff != COUNT_MAX) begin
                  miss_cnt_in = miss_cnt_ff + COUNT_W'(1);
               end
               if (fill_cut < size) begin
                  fill_in = fill_cut + FILL_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
         fill_ff       <= '0;
         req_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            table_size_ff <= csr_bus.table_size;
         end
         fill_ff      <= fill_in;
         req_cnt_ff   <= req_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         ignored_ff <= ignored;
         hit_ff     <= !ignored && hit;
         fault_ff   <= !ignored && !hit;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.ignored       = ignored_ff;
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.fault         = fault_ff;
   assign rsp_bus.request_total = req_cnt_ff;
   assign rsp_bus.miss_total    = miss_cnt_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill level above depth");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({ignored_ff, hit_ff, fault_ff}))
      else $error("response outcome not one-hot");

   a_req_count: assert property (@(posedge clock) disable iff (reset)
      (go && !ignored) |=> (req_cnt_ff != '0))
      else $error("request total zero after a request");

   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      (go && !ignored && !hit) |=> (miss_cnt_ff != '0) && (fill_ff != '0))
      else $error("fault left miss total or fill level at zero");

   a_miss_le_req: assert property (@(posedge clock) disable iff (reset)
      miss_cnt_ff <= req_cnt_ff)
      else $error("miss total above request total");
`endif

endmodule
